// File: rtl/core/pfr_pkg.sv
// Shared constants, types and helper functions for the polyphase FIR resampler.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package pfr_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int MAX_FACTOR  = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int DLY_DEPTH = MAX_TAPS + MAX_FACTOR;
  localparam int DLY_AW    = $clog2(DLY_DEPTH);
  localparam int TAP_AW    = $clog2(MAX_TAPS);
  localparam int PTR_W     = $clog2(MAX_TAPS);
  localparam int LEN_W     = $clog2(MAX_TAPS + 1);
  localparam int BANK_W    = $clog2(MAX_FACTOR);
  localparam int FACT_W    = 4;
  localparam int NTAP_W    = 7;
  localparam int CIDX_W    = 6;
  localparam int CFG_IW    = 2;
  localparam int CFG_DW    = 7;
  localparam int PROD_W    = 2 * SAMPLE_BITS;
  localparam int ACC_W     = 40;
  localparam int SAT_W     = ACC_W - SAMPLE_BITS + 2;
  localparam int RECIP_SH  = 16;
  localparam int RECIP_W   = RECIP_SH + 1;
  localparam int LENP_W    = NTAP_W + 1 + RECIP_W;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-(2 ** (SAMPLE_BITS - 1)));

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FACTOR = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TAPS   = 2'd2;

  // item kinds and resample modes
  localparam logic ITEM_SAMPLE  = 1'b0;
  localparam logic ITEM_COEF    = 1'b1;
  localparam logic RMODE_INTERP = 1'b0;
  localparam logic RMODE_DECIM  = 1'b1;

  typedef struct packed {
    logic coef_wr;
    logic start;
    logic calc_base;
    logic write_sample;
    logic issue;
    logic finish;
    logic next_bank;
  } pfr_cmd_t;

  typedef struct packed {
    logic decim;
    logic last_bank;
    logic issue_last;
    logic pipe_empty;
    logic out_busy;
  } pfr_stat_t;

  function automatic logic [FACT_W-1:0] eff_factor(input logic [FACT_W-1:0] f);
    logic [FACT_W-1:0] r;
    if (f == '0) r = FACT_W'(1);
    else if (int'(f) > MAX_FACTOR) r = FACT_W'(MAX_FACTOR);
    else r = f;
    return r;
  endfunction

  function automatic logic [NTAP_W-1:0] eff_taps(input logic [NTAP_W-1:0] n);
    logic [NTAP_W-1:0] r;
    if (n == '0) r = NTAP_W'(1);
    else if (int'(n) > MAX_TAPS) r = NTAP_W'(MAX_TAPS);
    else r = n;
    return r;
  endfunction

  // ceil(2^16 / f), exact enough for numerators below 2^8
  function automatic logic [RECIP_W-1:0] recip(input logic [FACT_W-1:0] f);
    logic [RECIP_W-1:0] r;
    case (f)
      4'd2:    r = RECIP_W'(32768);
      4'd3:    r = RECIP_W'(21846);
      4'd4:    r = RECIP_W'(16384);
      4'd5:    r = RECIP_W'(13108);
      4'd6:    r = RECIP_W'(10923);
      4'd7:    r = RECIP_W'(9363);
      4'd8:    r = RECIP_W'(8192);
      default: r = RECIP_W'(65536);
    endcase
    return r;
  endfunction

  // bank length ceil(n / f) by reciprocal multiply
  function automatic logic [LEN_W-1:0] calc_len(input logic [NTAP_W-1:0] n,
                                                input logic [FACT_W-1:0] f);
    logic [NTAP_W:0]    num;
    logic [LENP_W-1:0]  prod;
    num  = (NTAP_W+1)'(n) + (NTAP_W+1)'(f) - (NTAP_W+1)'(1);
    prod = LENP_W'(num) * LENP_W'(recip(f));
    return LEN_W'(prod >> RECIP_SH);
  endfunction

  // round half up then saturate to the sample width
  function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic [ACC_W:0]          r;
    logic signed [SAT_W-1:0] s;
    logic [SAMPLE_BITS-1:0]  o;
    r = {a[ACC_W-1], a} + (ACC_W+1)'(2 ** (SAMPLE_BITS - 2));
    s = r[ACC_W:SAMPLE_BITS-1];
    if (s > SAT_HI) o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    else if (s < SAT_LO) o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else o = s[SAMPLE_BITS-1:0];
    return o;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pfr_ctrl.sv
// Sequencer for the resampler: walks each bank through base, write, MAC, drain and emit.
// Depends on pfr_pkg; drives pfr_dp through pfr_cmd_t, watches pfr_stat_t.
`default_nettype none
module pfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              mode,
  output logic                   in_stall,
  output pfr_pkg::pfr_cmd_t      cmd,
  input  wire pfr_pkg::pfr_stat_t stat
);
  import pfr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BASE  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (mode == ITEM_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_BASE;
          end
        end
      end
      S_BASE: begin
        cmd.calc_base = 1'b1;
        state_next    = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_sample = 1'b1;
        state_next       = S_MAC;
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.pipe_empty) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          if (!stat.decim && !stat.last_bank) begin
            cmd.next_bank = 1'b1;
            state_next    = S_BASE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

// File: rtl/core/pfr_dp.sv
// Datapath: config registers, tap and delay memories, bank pointers, MAC pipe,
// decimation sum and output register. Depends on pfr_pkg; steered by pfr_ctrl.
`default_nettype none
module pfr_dp (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire pfr_pkg::pfr_cmd_t                          cmd,
  output pfr_pkg::pfr_stat_t                              stat,
  input  wire logic                                       cfg_valid,
  input  wire logic [pfr_pkg::CFG_IW-1:0]                 cfg_index,
  input  wire logic [pfr_pkg::CFG_DW-1:0]                 cfg_data,
  input  wire logic signed [pfr_pkg::SAMPLE_BITS-1:0]     sample,
  input  wire logic [pfr_pkg::CIDX_W-1:0]                 coef_index,
  input  wire logic signed [pfr_pkg::SAMPLE_BITS-1:0]     coef_value,
  input  wire logic                                       out_stall,
  output logic                                            out_valid,
  output logic [pfr_pkg::SAMPLE_BITS-1:0]                 out_sample,
  output logic                                            last
);
  import pfr_pkg::*;

  // configuration and values derived from it
  logic              rmode;
  logic [FACT_W-1:0] factor_q;
  logic [NTAP_W-1:0] taps_q;
  logic [FACT_W-1:0] eff_f;
  logic [NTAP_W-1:0] eff_n;
  logic [LEN_W-1:0]  lb;
  logic              cfg_clr;
  logic              clr;

  // per-item state
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [BANK_W-1:0]             bank;
  logic [BANK_W-1:0]             phase;
  logic [DLY_AW-1:0]             base;
  logic [BANK_W+LEN_W-1:0]       base_full;
  logic [PTR_W-1:0]              ptr [MAX_FACTOR];
  logic [PTR_W-1:0]              p_cur;
  logic [PTR_W-1:0]              p_use;
  logic [PTR_W-1:0]              idx;
  logic [PTR_W-1:0]              j;
  logic [DLY_AW-1:0]             tap;
  logic [DLY_AW-1:0]             rd_addr;
  logic [DLY_AW-1:0]             wr_addr;

  // memories with per-entry valid flags
  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] dly_mem  [DLY_DEPTH];
  logic [MAX_TAPS-1:0]           coef_vld;
  logic [DLY_DEPTH-1:0]          dly_vld;
  logic                          cidx_ok;

  // MAC pipe
  logic                          rd_v, prod_v;
  logic signed [SAMPLE_BITS-1:0] coef_q, dly_q;
  logic                          coef_ok, dly_ok;
  logic signed [SAMPLE_BITS-1:0] coef_use, dly_use;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       decim_sum;
  logic signed [ACC_W-1:0]       sum_tot;

  logic last_bank, group_done, emit;

  always_comb begin
    cfg_clr = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE, CFG_FACTOR, CFG_TAPS: cfg_clr = 1'b1;
        default:                        cfg_clr = 1'b0;
      endcase
    end
  end
  assign clr = cfg_clr | cmd.coef_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rmode    <= RMODE_INTERP;
      factor_q <= FACT_W'(1);
      taps_q   <= NTAP_W'(MAX_TAPS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:   rmode    <= cfg_data[0];
        CFG_FACTOR: factor_q <= cfg_data[FACT_W-1:0];
        CFG_TAPS:   taps_q   <= cfg_data[NTAP_W-1:0];
        default:    ;
      endcase
    end
  end

  assign eff_f = eff_factor(factor_q);
  assign eff_n = eff_taps(taps_q);

  // bank length is registered from the config registers; a taken sample passes base and write before its first read
  always_ff @(posedge clk) begin
    lb <= calc_len(eff_n, eff_f);
  end

  assign last_bank  = (FACT_W'(bank) + FACT_W'(1)) == eff_f;
  assign group_done = (FACT_W'(phase) + FACT_W'(1)) == eff_f;
  assign base_full  = (BANK_W+LEN_W)'(bank) * (BANK_W+LEN_W)'(lb);
  assign p_cur      = ptr[bank];
  assign p_use      = (LEN_W'(p_cur) >= lb) ? '0 : p_cur;
  assign wr_addr    = base + DLY_AW'(p_use);
  assign rd_addr    = base + DLY_AW'(idx);
  assign cidx_ok    = int'(coef_index) < MAX_TAPS;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_q <= sample;
    end
    if (cmd.calc_base) begin
      base <= base_full[DLY_AW-1:0];
    end
    if (cmd.write_sample) begin
      idx <= p_use;
      j   <= '0;
      tap <= DLY_AW'(bank);
    end else if (cmd.issue) begin
      idx <= (idx == '0) ? PTR_W'(lb - LEN_W'(1)) : idx - PTR_W'(1);
      j   <= j + PTR_W'(1);
      tap <= tap + DLY_AW'(eff_f);
    end
  end

  // bank select, pointers, phase and decimation sum
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < MAX_FACTOR; i++) ptr[i] <= '0;
      phase     <= '0;
      decim_sum <= '0;
      bank      <= '0;
    end else begin
      if (cmd.start) begin
        bank <= (rmode == RMODE_DECIM) ? BANK_W'(eff_f - FACT_W'(1)) - phase : '0;
      end else if (cmd.next_bank) begin
        bank <= bank + BANK_W'(1);
      end
      if (cmd.write_sample) begin
        ptr[bank] <= ((LEN_W'(p_use) + LEN_W'(1)) == lb) ? '0 : p_use + PTR_W'(1);
      end
      if (cmd.finish && rmode == RMODE_DECIM) begin
        if (group_done) begin
          decim_sum <= '0;
          phase     <= '0;
        end else begin
          decim_sum <= sum_tot;
          phase     <= phase + BANK_W'(1);
        end
      end
    end
  end

  // tap memory
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && cidx_ok) coef_mem[coef_index[TAP_AW-1:0]] <= coef_value;
    if (cmd.issue) coef_q <= coef_mem[tap[TAP_AW-1:0]];
  end

  // delay memory, all banks packed at base = bank * bank length
  always_ff @(posedge clk) begin
    if (cmd.write_sample) dly_mem[wr_addr] <= x_q;
    if (cmd.issue) dly_q <= dly_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      dly_vld  <= '0;
    end else begin
      if (cmd.coef_wr && cidx_ok) coef_vld[coef_index[TAP_AW-1:0]] <= 1'b1;
      if (clr) dly_vld <= '0;
      else if (cmd.write_sample) dly_vld[wr_addr] <= 1'b1;
    end
  end

  // padding taps read as zero
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      coef_ok <= coef_vld[tap[TAP_AW-1:0]] &&
                 ((NTAP_W+DLY_AW)'(tap) < (NTAP_W+DLY_AW)'(eff_n));
      dly_ok  <= dly_vld[rd_addr];
    end
  end

  assign coef_use = coef_ok ? coef_q : '0;
  assign dly_use  = dly_ok  ? dly_q  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= cmd.issue;
      prod_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) prod <= dly_use * coef_use;
    if (cmd.write_sample) acc <= '0;
    else if (prod_v) acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  assign sum_tot = decim_sum + acc;
  assign emit    = cmd.finish && (rmode == RMODE_INTERP || group_done);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (rmode == RMODE_INTERP) begin
        out_sample <= round_sat(acc);
        last       <= last_bank;
      end else begin
        out_sample <= round_sat(sum_tot);
        last       <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.decim      = (rmode == RMODE_DECIM);
    stat.last_bank  = last_bank;
    stat.issue_last = (LEN_W'(j) + LEN_W'(1)) == lb;
    stat.pipe_empty = !rd_v && !prod_v;
    stat.out_busy   = out_valid && out_stall;
  end

endmodule
`default_nettype wire

// File: rtl/core/polyphase_fir_resampler_unit.sv
// Polyphase FIR resampler, Q1.15 in and out, F banks of a prototype of up to 64 taps.
//
// Input channel (in_valid / in_stall): mode 0 carries a sample, mode 1 writes
// tap coef_value at coef_index. A word is taken when in_valid is high and
// in_stall low. A coefficient word leaves in_stall low and yields nothing.
// Output channel (out_valid / out_stall): out_sample with last on the final
// word produced by an input sample. Interpolate mode gives F words per sample,
// bank 0 first; decimate mode gives one word every F samples.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 mode, 1 factor,
// 2 tap count. Writes to indexes 0 to 2 and coefficient writes clear delay lines and phase.
// Each bank of Lb = ceil(taps / F) taps goes through base, write, MAC, drain
// and emit, on the single shared multiply-accumulate reading one tap and one
// delay entry per cycle. A sample runs all F banks when interpolating and one
// bank when decimating.
// in_stall is high while a sample is being worked on. A result waits in the
// output register under out_stall; the sequencer holds before overwriting it.
// Synchronous reset clears config to interpolate, factor 1, 64 taps, and
// marks all taps and delay entries as zero; no clearing pass is needed.
// Depends on pfr_pkg, pfr_ctrl and pfr_dp.
`default_nettype none
module polyphase_fir_resampler_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   mode,
  input  wire logic signed [pfr_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [pfr_pkg::CIDX_W-1:0]             coef_index,
  input  wire logic signed [pfr_pkg::SAMPLE_BITS-1:0] coef_value,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [pfr_pkg::SAMPLE_BITS-1:0]             out_sample,
  output logic                                        last,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [pfr_pkg::CFG_IW-1:0]             cfg_index,
  input  wire logic [pfr_pkg::CFG_DW-1:0]             cfg_data
);
  import pfr_pkg::*;

  pfr_cmd_t  cmd;
  pfr_stat_t stat;

  assign cfg_ready = 1'b1;

  pfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  pfr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_sample (out_sample),
    .last       (last)
  );

  // a sample word keeps the block busy for at least the next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == ITEM_SAMPLE |=> in_stall)
    else $error("sample word did not start processing");

  // a coefficient word leaves the input free in the next cycle
  a_coef_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == ITEM_COEF |=> !in_stall)
    else $error("coefficient word held the input");

  // decimated results are always the final word of their sample
  a_decim_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && stat.decim |-> last)
    else $error("decimated word without last");

  // nothing left in the MAC pipe when the block is ready for a new word
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> stat.pipe_empty)
    else $error("MAC pipe busy while idle");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for polyphase_fir_resampler_unit: directed table then random words,
// with a polyphase predictor and a queue of words due. Depends on pfr_pkg and the RTL.
module testbench;
  import pfr_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 500000;
  localparam logic [CFG_IW-1:0] CFG_NONE = 2'd3;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CFG_IW-1:0] ridx;
    logic [CFG_DW-1:0] rdata;
    logic              md;
    logic [15:0]       smp;
    logic [5:0]        ci;
    logic [15:0]       cv;
    logic              typed;
    logic [15:0]       want;
  } dir_row_t;

  typedef struct {
    logic [15:0] smp;
    logic        lst;
  } out_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   mode = ITEM_SAMPLE;
  logic signed [15:0]     sample = '0;
  logic [CIDX_W-1:0]      coef_index = '0;
  logic signed [15:0]     coef_value = '0;
  logic                   out_stall = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IW-1:0]      cfg_index = '0;
  logic [CFG_DW-1:0]      cfg_data = '0;
  logic                   in_stall;
  logic                   out_valid;
  logic [15:0]            out_sample;
  logic                   last;
  logic                   cfg_ready;

  polyphase_fir_resampler_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .sample     (sample),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic               rmode;
  logic [3:0]         fact_r;
  logic [6:0]         ntap_r;
  logic signed [15:0] taps [MAX_TAPS];
  logic signed [15:0] dline [DLY_DEPTH];
  int unsigned        bptr [MAX_FACTOR];
  int unsigned        grp_pos;
  longint             grp_acc;

  out_word_t   due_words [$];
  out_word_t   got_w;
  dir_row_t    dir_rows [$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycle_cnt = 0;
  bit          activity = 0;

  function automatic void append_due(input out_word_t w);
    due_words.insert(due_words.size(), w);
  endfunction

  function automatic void append_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic int unsigned eff_banks();
    if (fact_r == 0) return 1;
    if (fact_r > MAX_FACTOR) return MAX_FACTOR;
    return fact_r;
  endfunction

  function automatic int unsigned eff_ntaps();
    if (ntap_r == 0) return 1;
    if (ntap_r > MAX_TAPS) return MAX_TAPS;
    return ntap_r;
  endfunction

  function automatic void clear_lines();
    for (int i = 0; i < DLY_DEPTH; i++) dline[i] = '0;
    for (int i = 0; i < MAX_FACTOR; i++) bptr[i] = 0;
    grp_pos = 0;
    grp_acc = 0;
  endfunction

  function automatic logic [15:0] rnd_sat(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // push x into bank b's delay line and return that bank's dot product
  function automatic longint bank_mac(input int unsigned b, input logic signed [15:0] x);
    int unsigned f, n, lb, base, p, idx, t, j;
    logic signed [15:0] c;
    longint acc;
    f = eff_banks();
    n = eff_ntaps();
    lb = (n + f - 1) / f;
    base = b * lb;
    p = bptr[b];
    acc = 0;
    if (p >= lb) p = 0;
    dline[base + p] = x;
    idx = p;
    bptr[b] = (p + 1 == lb) ? 0 : p + 1;
    for (j = 0; j < lb; j++) begin
      t = b + j * f;
      c = (t < n) ? taps[t] : 16'sd0;
      acc += longint'(dline[base + idx]) * longint'(c);
      idx = (idx == 0) ? lb - 1 : idx - 1;
    end
    return acc;
  endfunction

  function automatic void resample_step(input logic md, input logic signed [15:0] x,
                                        input logic [5:0] ci, input logic signed [15:0] cv);
    int unsigned f;
    out_word_t w;
    f = eff_banks();
    if (md == ITEM_COEF) begin
      taps[ci] = cv;
      clear_lines();
    end else if (rmode == RMODE_INTERP) begin
      for (int unsigned b = 0; b < f; b++) begin
        w.smp = rnd_sat(bank_mac(b, x));
        w.lst = (b + 1 == f);
        append_due(w);
      end
    end else begin
      if (grp_pos >= f) grp_pos = 0;
      // commutator runs from the top bank down, bank 0 closes the group
      grp_acc += bank_mac(f - 1 - grp_pos, x);
      if (grp_pos + 1 == f) begin
        w.smp = rnd_sat(grp_acc);
        w.lst = 1'b1;
        append_due(w);
        grp_acc = 0;
        grp_pos = 0;
      end else begin
        grp_pos++;
      end
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] d);
    bit hit;
    hit = 1;
    case (idx)
      CFG_MODE:   rmode = d[0];
      CFG_FACTOR: fact_r = d[3:0];
      CFG_TAPS:   ntap_r = d[6:0];
      default:    hit = 0;
    endcase
    if (hit) clear_lines();
  endfunction

  function automatic void add_cfg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] d);
    dir_row_t r;
    r = '{kind: ROW_CFG, ridx: idx, rdata: d, md: ITEM_SAMPLE, smp: '0, ci: '0, cv: '0,
          typed: 1'b0, want: '0};
    append_row(r);
  endfunction

  function automatic void add_item(input logic md, input logic [15:0] s, input logic [5:0] ci,
                                   input logic [15:0] cv);
    dir_row_t r;
    r = '{kind: ROW_ITEM, ridx: '0, rdata: '0, md: md, smp: s, ci: ci, cv: cv,
          typed: 1'b0, want: '0};
    append_row(r);
  endfunction

  function automatic void add_chk(input logic [15:0] s, input logic [15:0] want);
    dir_row_t r;
    r = '{kind: ROW_ITEM, ridx: '0, rdata: '0, md: ITEM_SAMPLE, smp: s, ci: '0, cv: '0,
          typed: 1'b1, want: want};
    append_row(r);
  endfunction

  // hold the input side until every due word has left, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    if (activity) begin
      while (due_words.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      activity = 0;
    end
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] d);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, d);
  endtask

  task automatic send_item(input logic md, input logic [15:0] s, input logic [5:0] ci,
                           input logic [15:0] cv);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= md;
    sample     <= s;
    coef_index <= ci;
    coef_value <= cv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    resample_step(md, s, ci, cv);
    activity = 1;
  endtask

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        $display("%0t: word with none due, expected none, actual out_sample=%h last=%b",
                 $time, out_sample, last);
        errors++;
      end else begin
        got_w = due_words.pop_front();
        if (out_sample !== got_w.smp) begin
          $display("%0t: out_sample mismatch, expected %h, actual %h",
                   $time, got_w.smp, out_sample);
          errors++;
        end
        if (last !== got_w.lst) begin
          $display("%0t: last mismatch, expected %b, actual %b", $time, got_w.lst, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int seg, k, n_seg;
    logic [15:0] s, cv;
    logic [5:0] ci;
    logic md;
    dir_row_t r;
    out_word_t w;

    rmode  = RMODE_INTERP;
    fact_r = 4'd1;
    ntap_r = 7'd64;
    for (int i = 0; i < MAX_TAPS; i++) taps[i] = '0;
    clear_lines();

    // after reset the taps are zero, so the output is zero at the extremes
    add_chk(16'h7FFF, 16'h0000);
    add_chk(16'h8000, 16'h0000);
    add_item(ITEM_COEF, '0, 6'd0, 16'h7FFF);
    add_chk(16'h7FFF, 16'h7FFE);
    add_chk(16'h8000, 16'h8001);
    // -1 * -1 saturates high
    add_item(ITEM_COEF, '0, 6'd0, 16'h8000);
    add_chk(16'h8000, 16'h7FFF);
    add_item(ITEM_COEF, '0, 6'd1, 16'h8000);
    add_chk(16'h7FFF, 16'h8001);
    add_chk(16'h7FFF, 16'h8000);
    add_item(ITEM_COEF, '0, 6'd63, 16'h5A5A);
    add_item(ITEM_SAMPLE, 16'h1234, '0, '0);
    // tap 63 now sits in the padding and must read zero
    add_cfg(CFG_TAPS, 7'd2);
    add_item(ITEM_SAMPLE, 16'h4000, '0, '0);
    add_item(ITEM_SAMPLE, 16'hC000, '0, '0);
    add_cfg(CFG_NONE, 7'h7F);
    add_cfg(CFG_MODE, CFG_DW'(RMODE_DECIM));
    add_cfg(CFG_FACTOR, 7'd3);
    add_cfg(CFG_TAPS, 7'd64);
    for (int i = 0; i < 6; i++) add_item(ITEM_SAMPLE, 16'h2000 + 16'(i * 977), '0, '0);
    add_cfg(CFG_FACTOR, 7'd0);
    add_item(ITEM_SAMPLE, 16'h7FFF, '0, '0);
    add_item(ITEM_SAMPLE, 16'h8000, '0, '0);
    add_cfg(CFG_MODE, CFG_DW'(RMODE_INTERP));
    add_cfg(CFG_FACTOR, 7'd15);
    add_cfg(CFG_TAPS, 7'd127);
    add_item(ITEM_SAMPLE, 16'h7FFF, '0, '0);
    add_item(ITEM_SAMPLE, 16'h8001, '0, '0);
    add_cfg(CFG_TAPS, 7'd0);
    add_item(ITEM_SAMPLE, 16'h5555, '0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) begin
        cfg_write(r.ridx, r.rdata);
      end else begin
        send_item(r.md, r.smp, r.ci, r.cv);
        if (r.typed) begin
          w = due_words.pop_back();
          w.smp = r.want;
          append_due(w);
        end
      end
    end

    // fill the whole prototype with taps of mixed magnitude
    for (int i = 0; i < MAX_TAPS; i++) begin
      cv = 16'($urandom);
      cv = 16'($signed(cv) >>> $urandom_range(0, 6));
      send_item(ITEM_COEF, 16'($urandom), 6'(i), cv);
    end

    n_seg = 8;
    for (seg = 0; seg < n_seg; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      case (seg)
        0: begin
          cfg_write(CFG_MODE, CFG_DW'(RMODE_INTERP));
          cfg_write(CFG_FACTOR, 7'd1);
          cfg_write(CFG_TAPS, 7'd64);
        end
        1: begin
          cfg_write(CFG_MODE, CFG_DW'(RMODE_DECIM));
          cfg_write(CFG_FACTOR, 7'd8);
          cfg_write(CFG_TAPS, 7'd64);
        end
        2: begin
          cfg_write(CFG_MODE, CFG_DW'(RMODE_INTERP));
          cfg_write(CFG_FACTOR, 7'd8);
          cfg_write(CFG_TAPS, 7'd64);
        end
        3: begin
          cfg_write(CFG_MODE, CFG_DW'(RMODE_DECIM));
          cfg_write(CFG_FACTOR, 7'd2);
          cfg_write(CFG_TAPS, 7'd5);
        end
        default: begin
          cfg_write(CFG_MODE, 7'($urandom_range(0, 1)));
          cfg_write(CFG_FACTOR, 7'($urandom_range(0, 15)));
          if ($urandom_range(1) == 0) cfg_write(CFG_TAPS, 7'($urandom_range(1, 16)));
          else cfg_write(CFG_TAPS, 7'($urandom_range(0, 127)));
          if ($urandom_range(3) == 0) cfg_write(CFG_NONE, 7'($urandom));
        end
      endcase
      for (k = 0; k < 15; k++) begin
        if (seg == 5 && k == 9) begin
          // let the output side run dry mid-stream
          in_valid <= 1'b0;
          do @(posedge clk); while (due_words.size() != 0);
        end
        s  = 16'($urandom);
        ci = 6'($urandom);
        cv = 16'($urandom);
        md = ($urandom_range(99) < 8) ? ITEM_COEF : ITEM_SAMPLE;
        if (md == ITEM_SAMPLE && $urandom_range(9) == 0)
          s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        send_item(md, s, ci, cv);
      end
    end

    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pfr_pkg.sv
rtl/core/pfr_ctrl.sv
rtl/core/pfr_dp.sv
rtl/core/polyphase_fir_resampler_unit.sv
tb/sv/testbench.sv
